[rtl/afcpt_pkg.sv]
`default_nettype none

package afcpt_pkg;

  // stream and field widths
  localparam int unsigned WordW    = 32;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned FrmW     = 12;
  localparam int unsigned CntW     = 10;
  localparam int unsigned SizeW    = WordW - 2;
  localparam int unsigned MagW     = 23;
  localparam int unsigned NumW     = 32;
  localparam int unsigned RecipW   = 33;
  localparam int unsigned ProdW    = NumW + RecipW;
  localparam int unsigned QuotW    = 19;
  localparam int unsigned PeakW    = 28;
  localparam int unsigned VoltW    = 29;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;
  localparam logic [CfgIdxW-1:0] CfgChannelId     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxFrameBytes = 2'd1;
  localparam logic [ChanW-1:0]   ChannelIdRst     = 8'd234;
  localparam logic [FrmW-1:0]    MaxFrameRst      = 12'd1500;

  // framing
  localparam logic [WordW-1:0] SyncWord = 32'hFFFF_FFFF;
  localparam logic [CntW-1:0]  CntMax   = '1;

  // volts = floor(raw * 2^18 / 9375), folded as
  // q = 28*(u+1) - floor((356*u + off) / 9375) on the magnitude u
  localparam logic [NumW-1:0]   VoltMul    = 32'd356;
  localparam logic [NumW-1:0]   OffPos     = 32'd271874;
  localparam logic [NumW-1:0]   OffNeg     = 32'd9731;
  localparam logic [RecipW-1:0] RecipM     = 33'd7505999379;
  localparam int unsigned       RecipShift = 46;
  localparam logic [PeakW-1:0]  BaseMul    = 28'd28;

  typedef struct packed {
    logic [ChanW-1:0] channel_id;
    logic [FrmW-1:0]  max_frame_bytes;
  } cfg_t;

  // deframer to converter
  typedef struct packed {
    logic            sof;
    logic            skipped;
    logic            smp_valid;
    logic            sign;
    logic [MagW-1:0] mag;
    logic [NumW-1:0] num;
  } parse_t;

  // converter to peak tracker
  typedef struct packed {
    logic                    sof;
    logic                    skipped;
    logic                    smp_valid;
    logic signed [VoltW-1:0] volts;
  } conv_t;

  // result transaction
  typedef struct packed {
    logic                    sample_valid;
    logic signed [VoltW-1:0] sample_volts;
    logic                    frame_skipped;
    logic [PeakW-1:0]        max_first;
    logic [PeakW-1:0]        max_second;
    logic signed [VoltW-1:0] min_first;
    logic signed [VoltW-1:0] min_second;
  } res_t;

endpackage

`default_nettype wire

[rtl/afcpt_if.sv]
`default_nettype none

// input stream channel
interface afcpt_in_if;
  logic                          valid;
  logic                          ready;
  logic [afcpt_pkg::WordW-1:0]   stream_word;
  logic                          start_of_file;

  modport source (output valid, output stream_word, output start_of_file, input ready);
  modport sink   (input valid, input stream_word, input start_of_file, output ready);
endinterface

// result channel
interface afcpt_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 sample_valid;
  logic signed [afcpt_pkg::VoltW-1:0]   sample_volts;
  logic                                 frame_skipped;
  logic [afcpt_pkg::PeakW-1:0]          max_first;
  logic [afcpt_pkg::PeakW-1:0]          max_second;
  logic signed [afcpt_pkg::VoltW-1:0]   min_first;
  logic signed [afcpt_pkg::VoltW-1:0]   min_second;

  modport source (output valid, output sample_valid, output sample_volts,
                  output frame_skipped, output max_first, output max_second,
                  output min_first, output min_second, input ready);
  modport sink   (input valid, input sample_valid, input sample_volts,
                  input frame_skipped, input max_first, input max_second,
                  input min_first, input min_second, output ready);
endinterface

`default_nettype wire

[rtl/afcpt_deframer.sv]
`default_nettype none

module afcpt_deframer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire afcpt_pkg::cfg_t              cfg_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [afcpt_pkg::WordW-1:0]  in_word_i,
  input  wire logic                         in_sof_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output afcpt_pkg::parse_t                 out_o
);

  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhHeader  = 2'd1;
  localparam logic [1:0] PhSize    = 2'd2;
  localparam logic [1:0] PhPayload = 2'd3;

  logic                              a_vld_q;
  logic [afcpt_pkg::WordW-1:0]       a_word_q;
  logic                              a_sof_q;
  logic                              b_vld_q;
  afcpt_pkg::parse_t                 b_q;
  afcpt_pkg::parse_t                 b_d;
  logic                              a_ready;
  logic                              b_ready;
  logic                              a_move;

  logic [1:0]                        phase_q;
  logic [1:0]                        phase_d;
  logic [1:0]                        phase_cur;
  logic [afcpt_pkg::CntW-1:0]        wl_q;
  logic [afcpt_pkg::CntW-1:0]        wl_d;
  logic [afcpt_pkg::CntW-1:0]        wl_cur;
  logic [afcpt_pkg::CntW-1:0]        wl_dec;
  logic [afcpt_pkg::CntW-1:0]        size_n;
  logic [afcpt_pkg::SizeW-1:0]       size_words;
  logic                              skipped;
  logic                              smp;
  logic                              sign;
  logic [afcpt_pkg::MagW-1:0]        mag;

  // two-register pipe with per-stage stall
  assign b_ready     = !b_vld_q || out_ready_i;
  assign a_ready     = !a_vld_q || b_ready;
  assign a_move      = a_vld_q && b_ready;
  assign in_ready_o  = a_ready;
  assign out_valid_o = b_vld_q;
  assign out_o       = b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      phase_q <= PhHunt;
      wl_q    <= '0;
    end else begin
      if (a_ready) begin
        a_vld_q <= in_valid_i;
      end
      if (b_ready) begin
        b_vld_q <= a_vld_q;
      end
      if (a_move) begin
        phase_q <= phase_d;
        wl_q    <= wl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_word_q <= in_word_i;
      a_sof_q  <= in_sof_i;
    end
    if (a_move) begin
      b_q <= b_d;
    end
  end

  // size in words, saturated to the counter
  assign size_words = a_word_q[afcpt_pkg::WordW-1:2];
  assign size_n     = (size_words > afcpt_pkg::SizeW'(afcpt_pkg::CntMax)) ?
                      afcpt_pkg::CntMax : size_words[afcpt_pkg::CntW-1:0];

  // frame parser
  always_comb begin
    phase_cur = a_sof_q ? PhHunt : phase_q;
    wl_cur    = a_sof_q ? '0 : wl_q;
    phase_d   = phase_cur;
    wl_d      = wl_cur;
    wl_dec    = '0;
    skipped   = 1'b0;
    smp       = 1'b0;
    unique case (phase_cur)
      PhHunt: begin
        if (a_word_q == afcpt_pkg::SyncWord) begin
          phase_d = PhHeader;
        end
      end
      PhHeader: begin
        phase_d = a_word_q[afcpt_pkg::WordW-1] ? PhHunt : PhSize;
      end
      PhSize: begin
        if (a_word_q > afcpt_pkg::WordW'(cfg_i.max_frame_bytes)) begin
          skipped = 1'b1;
          phase_d = PhHunt;
        end else begin
          wl_d    = size_n;
          phase_d = (size_n == '0) ? PhHunt : PhPayload;
        end
      end
      PhPayload: begin
        smp    = (a_word_q[afcpt_pkg::WordW-1 -: afcpt_pkg::ChanW] == cfg_i.channel_id);
        wl_dec = (wl_cur != '0) ? wl_cur - 1'b1 : '0;
        wl_d   = wl_dec;
        if (wl_dec == '0) begin
          phase_d = PhHunt;
        end
      end
    endcase
  end

  // magnitude and folded numerator for the volt scaling
  assign sign = a_word_q[afcpt_pkg::MagW];
  assign mag  = a_word_q[afcpt_pkg::MagW-1:0] ^ {afcpt_pkg::MagW{sign}};

  always_comb begin
    b_d.sof       = a_sof_q;
    b_d.skipped   = skipped;
    b_d.smp_valid = smp;
    b_d.sign      = sign;
    b_d.mag       = mag;
    b_d.num       = afcpt_pkg::NumW'(mag) * afcpt_pkg::VoltMul +
                    (sign ? afcpt_pkg::OffNeg : afcpt_pkg::OffPos);
  end

endmodule

`default_nettype wire

[rtl/afcpt_volt_conv.sv]
`default_nettype none

module afcpt_volt_conv (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire afcpt_pkg::parse_t  in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output afcpt_pkg::conv_t        out_o
);

  logic                              c_vld_q;
  logic [afcpt_pkg::QuotW-1:0]       c_quot_q;
  logic [afcpt_pkg::PeakW-1:0]       c_base_q;
  logic                              c_sign_q;
  logic                              c_sof_q;
  logic                              c_skip_q;
  logic                              c_smp_q;
  logic                              d_vld_q;
  afcpt_pkg::conv_t                  d_q;
  afcpt_pkg::conv_t                  d_d;
  logic                              c_ready;
  logic                              d_ready;
  logic [afcpt_pkg::ProdW-1:0]       prod;
  logic [afcpt_pkg::PeakW-1:0]       base;
  logic [afcpt_pkg::PeakW-1:0]       q_mag;
  logic signed [afcpt_pkg::VoltW-1:0] q_ext;

  assign d_ready     = !d_vld_q || out_ready_i;
  assign c_ready     = !c_vld_q || d_ready;
  assign in_ready_o  = c_ready;
  assign out_valid_o = d_vld_q;
  assign out_o       = d_q;

  // reciprocal multiply for the division by 9375, plus the 28*(u+1) term
  assign prod = afcpt_pkg::ProdW'(in_i.num) * afcpt_pkg::ProdW'(afcpt_pkg::RecipM);
  assign base = afcpt_pkg::PeakW'(in_i.mag) * afcpt_pkg::BaseMul + afcpt_pkg::BaseMul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_vld_q <= in_valid_i;
      end
      if (d_ready) begin
        d_vld_q <= c_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_quot_q <= prod[afcpt_pkg::RecipShift +: afcpt_pkg::QuotW];
      c_base_q <= base;
      c_sign_q <= in_i.sign;
      c_sof_q  <= in_i.sof;
      c_skip_q <= in_i.skipped;
      c_smp_q  <= in_i.smp_valid;
    end
    if (c_vld_q && d_ready) begin
      d_q <= d_d;
    end
  end

  // quotient of the magnitude, then ones' complement back for negatives
  assign q_mag = c_base_q - afcpt_pkg::PeakW'(c_quot_q);
  assign q_ext = {1'b0, q_mag};

  always_comb begin
    d_d.sof       = c_sof_q;
    d_d.skipped   = c_skip_q;
    d_d.smp_valid = c_smp_q;
    if (!c_smp_q) begin
      d_d.volts = '0;
    end else if (c_sign_q) begin
      d_d.volts = ~q_ext;
    end else begin
      d_d.volts = q_ext;
    end
  end

endmodule

`default_nettype wire

[rtl/afcpt_peak_track.sv]
`default_nettype none

module afcpt_peak_track (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire afcpt_pkg::conv_t  in_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output afcpt_pkg::res_t        res_o
);

  logic                               e_vld_q;
  logic                               e_smp_q;
  logic signed [afcpt_pkg::VoltW-1:0] e_volts_q;
  logic                               e_skip_q;
  logic                               fire;

  logic [afcpt_pkg::PeakW-1:0]        mx1_q, mx2_q, mx1_d, mx2_d, mx1_c, mx2_c;
  logic signed [afcpt_pkg::VoltW-1:0] mn1_q, mn2_q, mn1_d, mn2_d, mn1_c, mn2_c;
  logic signed [afcpt_pkg::VoltW-1:0] mx1_s, mx2_s;
  logic signed [afcpt_pkg::VoltW-1:0] v;

  // output register; the peak registers are the result's peak fields
  assign in_ready_o  = !e_vld_q || res_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign res_valid_o = e_vld_q;

  always_comb begin
    res_o.sample_valid  = e_smp_q;
    res_o.sample_volts  = e_volts_q;
    res_o.frame_skipped = e_skip_q;
    res_o.max_first     = mx1_q;
    res_o.max_second    = mx2_q;
    res_o.min_first     = mn1_q;
    res_o.min_second    = mn2_q;
  end

  // peaks as seen by this transaction, cleared on start of file
  assign mx1_c = in_i.sof ? '0 : mx1_q;
  assign mx2_c = in_i.sof ? '0 : mx2_q;
  assign mn1_c = in_i.sof ? '0 : mn1_q;
  assign mn2_c = in_i.sof ? '0 : mn2_q;
  assign mx1_s = {1'b0, mx1_c};
  assign mx2_s = {1'b0, mx2_c};
  assign v     = in_i.volts;

  // distinct top-two tracking on both ends
  always_comb begin
    mx1_d = mx1_c;
    mx2_d = mx2_c;
    mn1_d = mn1_c;
    mn2_d = mn2_c;
    if (in_i.smp_valid) begin
      if (v > mx1_s) begin
        mx2_d = mx1_c;
        mx1_d = v[afcpt_pkg::PeakW-1:0];
      end else if (v > mx2_s && v != mx1_s) begin
        mx2_d = v[afcpt_pkg::PeakW-1:0];
      end
      if (v < mn1_c) begin
        mn2_d = mn1_c;
        mn1_d = v;
      end else if (v < mn2_c && v != mn1_c) begin
        mn2_d = v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      mx1_q   <= '0;
      mx2_q   <= '0;
      mn1_q   <= '0;
      mn2_q   <= '0;
    end else begin
      if (in_ready_o) begin
        e_vld_q <= in_valid_i;
      end
      if (fire) begin
        mx1_q <= mx1_d;
        mx2_q <= mx2_d;
        mn1_q <= mn1_d;
        mn2_q <= mn2_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      e_smp_q   <= in_i.smp_valid;
      e_volts_q <= in_i.volts;
      e_skip_q  <= in_i.skipped;
    end
  end

endmodule

`default_nettype wire

[rtl/adc_frame_channel_peak_tracker_unit.sv]
// channel   | dir | handshake         | payload
// ----------+-----+-------------------+-----------------------------------------
// in_i      | in  | valid/ready       | stream_word, start_of_file
// res_o     | out | valid/ready       | sample_valid, sample_volts, frame_skipped,
//           |     |                   | max_first, max_second, min_first, min_second
// cfg       | in  | cfg_we_i          | cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle while the result channel is ready; each word passes through
// the five register stages: input, parse, multiply, volt fix-up, output
// the volt scaling is a 32x33 reciprocal multiply with its own register stage
// every stage stalls on its own, so bubbles are absorbed while the output waits
// reset clears the parser, the peaks, the pipe valids and restores the registers

`default_nettype none

module adc_frame_channel_peak_tracker_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [afcpt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [afcpt_pkg::CfgDataW-1:0]   cfg_wdata_i,
  afcpt_in_if.sink                              in_i,
  afcpt_res_if.source                           res_o
);

  afcpt_pkg::cfg_t   cfg_q;
  afcpt_pkg::parse_t prs;
  afcpt_pkg::conv_t  cnv;
  afcpt_pkg::res_t   res;
  logic              prs_valid;
  logic              prs_ready;
  logic              cnv_valid;
  logic              cnv_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_id      <= afcpt_pkg::ChannelIdRst;
      cfg_q.max_frame_bytes <= afcpt_pkg::MaxFrameRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        afcpt_pkg::CfgChannelId: begin
          cfg_q.channel_id <= cfg_wdata_i[afcpt_pkg::ChanW-1:0];
        end
        afcpt_pkg::CfgMaxFrameBytes: begin
          cfg_q.max_frame_bytes <= cfg_wdata_i[afcpt_pkg::FrmW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  afcpt_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_word_i   (in_i.stream_word),
    .in_sof_i    (in_i.start_of_file),
    .out_valid_o (prs_valid),
    .out_ready_i (prs_ready),
    .out_o       (prs)
  );

  afcpt_volt_conv u_volt_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prs_valid),
    .in_ready_o  (prs_ready),
    .in_i        (prs),
    .out_valid_o (cnv_valid),
    .out_ready_i (cnv_ready),
    .out_o       (cnv)
  );

  afcpt_peak_track u_peak_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cnv_valid),
    .in_ready_o  (cnv_ready),
    .in_i        (cnv),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  // result transaction onto the channel
  assign res_o.sample_valid  = res.sample_valid;
  assign res_o.sample_volts  = res.sample_volts;
  assign res_o.frame_skipped = res.frame_skipped;
  assign res_o.max_first     = res.max_first;
  assign res_o.max_second    = res.max_second;
  assign res_o.min_first     = res.min_first;
  assign res_o.min_second    = res.min_second;

endmodule

`default_nettype wire
